### hdl/masked_byte_pattern_scanner_top_defines.svh
// Assertion macros for the signature scanner.
// Each macro carries its own trailing semicolon; write one use per line.
`ifndef MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MBPS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mbps same-cycle check failed");
// Next-cycle implication.
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mbps next-cycle check failed");
`else
`define MBPS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### hdl/mbps_pkg.sv
package mbps_pkg;

    // Width used for lengths and positions inside the cells (holds up to 256).
    localparam int PCNT_W = 9;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              shift_win;  // shift a new image byte into the window
        logic              clr_win;    // clear the window at end of image
        logic              shift_sig;  // shift one aligned signature entry in
        logic              ld_en;      // direct write of a loaded signature entry
        logic [PCNT_W-1:0] ld_pos;     // loaded position
        logic [7:0]        ld_val;
        logic              ld_wild;
        logic [PCNT_W-1:0] clen;       // length in use (1..MAX_PATTERN)
    } cell_ctrl_t;

endpackage

### hdl/mbps_ram.sv
module mbps_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mbps_cell.sv
// One window position: image byte of age IDX, aligned signature entry
// sig[len-1-IDX], and the registered compare result.
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] win_in,
    input  logic [7:0] sig_in,
    input  logic       wild_in,
    output logic [7:0] win_out,
    output logic [7:0] sig_out,
    output logic       wild_out,
    output logic       hit_out
);

    localparam logic [PCNT_W-1:0] MY_IDX = PCNT_W'(IDX);

    logic [7:0] win_reg;
    logic [7:0] sig_reg;
    logic       wild_reg;
    logic       hit_reg;
    logic       active;
    logic       ld_sel;

    assign active = (MY_IDX < ctrl.clen);
    // a load of position p lands in the cell where IDX == len-1-p
    assign ld_sel = ctrl.ld_en && active && (ctrl.ld_pos == (ctrl.clen - 1'b1 - MY_IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (ctrl.clr_win) begin
            win_reg <= '0;
        end else if (ctrl.shift_win) begin
            win_reg <= win_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_sig) begin
            sig_reg  <= sig_in;
            wild_reg <= wild_in;
        end else if (ld_sel) begin
            sig_reg  <= ctrl.ld_val;
            wild_reg <= ctrl.ld_wild;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= !active || wild_reg || (win_reg == sig_reg);
    end

    assign win_out  = win_reg;
    assign sig_out  = sig_reg;
    assign wild_out = wild_reg;
    assign hit_out  = hit_reg;

endmodule

### hdl/masked_byte_pattern_scanner_top.sv
// Result path: a load passes ST_RES before tvalid rises, a scan byte ST_CMP then ST_RES.
// Flow: one transaction in flight; ST_RES holds while the result output is stalled.
// The window compare is a row of MAX_PATTERN cells, checked in parallel, ANDed next cycle.
// A config write re-aligns the signature: input held off in the write cycle and while
// ST_BUILD reads the clamped length of entries from the store into the row.
// Reset (aresetn, sync, active low): window zeroed, counters cleared, length 1; signature kept.
`include "masked_byte_pattern_scanner_top_defines.svh"

module masked_byte_pattern_scanner_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: pattern_length
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [5:0] position, [13:6] pattern_value,
                                   // [14] wildcard_req, [22:15] image_byte, [23] zero
    input  logic        s_tuser,   // kind: 0 = load, 1 = scan
    input  logic        s_tlast,   // last byte of the image
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [33:2] match_offset, [39:34] zero
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [PCNT_W-1:0] MAX_P = PCNT_W'(MAX_PATTERN);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef enum logic [1:0] {
        STAT_NONE    = 2'd0,
        STAT_FOUND   = 2'd1,
        STAT_EARLIER = 2'd2,
        STAT_MISS    = 2'd3
    } status_t;

    // one-hot sequencer
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_RES   = 4'b0100,
        ST_BUILD = 4'b1000
    } state_t;

    state_t      st_reg, st_next;
    logic        kind_reg;
    logic        last_reg;
    logic [31:0] seen_reg;
    logic        found_reg;
    logic [31:0] foff_reg;
    logic [6:0]  len_reg;
    logic [LW-1:0] rd_cnt_reg;
    logic        rd_pend_reg;
    logic        m_tvalid_reg;
    status_t     m_status_reg;
    logic [31:0] m_off_reg;

    // input field unpacking
    logic [5:0]  in_pos;
    logic [7:0]  in_pval;
    logic        in_wild;
    logic [7:0]  in_byte;
    logic [PCNT_W-1:0] pos9;

    assign in_pos  = s_tdata[5:0];
    assign in_pval = s_tdata[13:6];
    assign in_wild = s_tdata[14];
    assign in_byte = s_tdata[22:15];
    assign pos9    = PCNT_W'(in_pos);

    // length in use, clamped to 1..MAX_PATTERN
    logic [PCNT_W-1:0] clen;
    always_comb begin
        if (len_reg == 7'd0) begin
            clen = PCNT_W'(1);
        end else if (PCNT_W'(len_reg) > MAX_P) begin
            clen = MAX_P;
        end else begin
            clen = PCNT_W'(len_reg);
        end
    end

    logic in_acc, out_free, res_fire, ld_acc, scan_acc, rd_issue;
    // no transaction is taken in the cycle of a length write
    assign s_tready = (st_reg == ST_IDLE) && !cfg_wr_en;
    assign in_acc   = s_tvalid && s_tready;
    assign ld_acc   = in_acc && (s_tuser == KIND_LOAD);
    assign scan_acc = in_acc && (s_tuser == KIND_SCAN);
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_fire = (st_reg == ST_RES) && out_free;
    assign rd_issue = (st_reg == ST_BUILD) && (PCNT_W'(rd_cnt_reg) < clen);

    // signature store, indexed by position
    logic [8:0] ram_rdata;
    mbps_ram #(
        .WIDTH (9),
        .DEPTH (MAX_PATTERN)
    ) u_sig_ram (
        .clk   (aclk),
        .we    (ld_acc && (pos9 < MAX_P)),
        .waddr (pos9[AW-1:0]),
        .wdata ({in_wild, in_pval}),
        .re    (rd_issue),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // cell row: window shifts upward from cell 0, aligned signature too
    cell_ctrl_t ctrl;
    assign ctrl.shift_win = scan_acc;
    assign ctrl.clr_win   = res_fire && (kind_reg == KIND_SCAN) && last_reg;
    assign ctrl.shift_sig = rd_pend_reg;
    assign ctrl.ld_en     = ld_acc;
    assign ctrl.ld_pos    = pos9;
    assign ctrl.ld_val    = in_pval;
    assign ctrl.ld_wild   = in_wild;
    assign ctrl.clen      = clen;

    logic [7:0]             win_w  [MAX_PATTERN];
    logic [7:0]             sig_w  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] wild_w;
    logic [MAX_PATTERN-1:0] hit_w;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] win_i;
        logic [7:0] sig_i;
        logic       wild_i;
        if (k == 0) begin : g_head
            assign win_i  = in_byte;
            assign sig_i  = ram_rdata[7:0];
            assign wild_i = ram_rdata[8];
        end else begin : g_body
            assign win_i  = win_w[k-1];
            assign sig_i  = sig_w[k-1];
            assign wild_i = wild_w[k-1];
        end
        mbps_cell #(
            .IDX (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .win_in   (win_i),
            .sig_in   (sig_i),
            .wild_in  (wild_i),
            .win_out  (win_w[k]),
            .sig_out  (sig_w[k]),
            .wild_out (wild_w[k]),
            .hit_out  (hit_w[k])
        );
    end

    // result stage: all cells hit and enough bytes seen
    logic        win_match;
    logic        new_found;
    status_t     res_status;
    logic [31:0] res_off;
    assign win_match = (&hit_w) && (seen_reg >= 32'(clen));

    always_comb begin
        res_status = STAT_NONE;
        res_off    = '0;
        new_found  = 1'b0;
        if (kind_reg == KIND_SCAN) begin
            if (found_reg) begin
                res_status = STAT_EARLIER;
                res_off    = foff_reg;
            end else if (win_match) begin
                new_found  = 1'b1;
                res_status = STAT_FOUND;
                res_off    = seen_reg - 32'(clen);
            end
            if (last_reg && !found_reg && !new_found) begin
                res_status = STAT_MISS;
                res_off    = '0;
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    st_next = (s_tuser == KIND_SCAN) ? ST_CMP : ST_RES;
                end
            end
            ST_CMP:   st_next = ST_RES;
            ST_RES: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            ST_BUILD: begin
                if (!rd_issue && !rd_pend_reg) begin
                    st_next = ST_IDLE;
                end
            end
            default:  st_next = ST_IDLE;
        endcase
        // a length change re-aligns the signature row
        if (cfg_wr_en) begin
            st_next = ST_BUILD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            seen_reg     <= '0;
            found_reg    <= 1'b0;
            foff_reg     <= '0;
            len_reg      <= 7'd1;
            rd_cnt_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_wr_en) begin
                len_reg     <= cfg_wr_data;
                rd_cnt_reg  <= '0;
                rd_pend_reg <= 1'b0;
            end else begin
                rd_pend_reg <= rd_issue;
                if (rd_issue) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
            end
            if (scan_acc && (seen_reg != 32'hFFFF_FFFF)) begin
                seen_reg <= seen_reg + 32'd1;
            end
            if (res_fire) begin
                m_tvalid_reg <= 1'b1;
                if (new_found) begin
                    found_reg <= 1'b1;
                    foff_reg  <= res_off;
                end
                if (ctrl.clr_win) begin
                    seen_reg  <= '0;
                    found_reg <= 1'b0;
                    foff_reg  <= '0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
        end
        if (res_fire) begin
            m_status_reg <= res_status;
            m_off_reg    <= res_off;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_off_reg, m_status_reg};

    // rebuild never reads past the length in use
    `MBPS_ASSERT_SAME(a_build_bound, aclk, aresetn, (st_reg == ST_BUILD), (PCNT_W'(rd_cnt_reg) <= clen))
    // the last byte of an image leaves the scan state cleared
    `MBPS_ASSERT_NEXT(a_last_clears, aclk, aresetn, ctrl.clr_win, ((seen_reg == 32'd0) && !found_reg))
    // a load transaction always reports no match
    `MBPS_ASSERT_NEXT(a_load_status, aclk, aresetn, (res_fire && (kind_reg == KIND_LOAD)), (m_tvalid && (m_tdata[1:0] == STAT_NONE)))

endmodule
